// ===== sv/per_line_record_fifo_sine_synth_core_assert.svh =====
// Assertion macros used by the engine RTL of the line record core.
`ifndef PER_LINE_RECORD_FIFO_SINE_SYNTH_CORE_ASSERT_SVH
`define PER_LINE_RECORD_FIFO_SINE_SYNTH_CORE_ASSERT_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define PLRF_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition on the right must hold in the cycle after the one on the left.
`define PLRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/plrf_pkg.sv =====
package plrf_pkg;

   localparam int MAX_LINES         = 16;
   localparam int FIFO_DEPTH        = 8;
   localparam int SAMPLES_PER_FETCH = 120;

   localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int COUNT_W = $clog2(MAX_LINES + 1);
   localparam int SLOT_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);
   localparam int REC_DEPTH = MAX_LINES * FIFO_DEPTH;
   localparam int REC_AW  = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
   localparam int SAMP_W  = $clog2(SAMPLES_PER_FETCH);

   localparam int KEY_W   = 24;
   localparam int FREQ_W  = 24;
   localparam int MAG_W   = 23;
   localparam int PHASE_W = 24;
   localparam int ENV_W   = 19;
   localparam int SMP_W   = 20;
   localparam int REC_W   = FREQ_W + MAG_W;

   localparam int AMP_CLAMP = 327680;
   localparam int NUM_W = $clog2(AMP_CLAMP * SAMPLES_PER_FETCH + SAMPLES_PER_FETCH / 2 + 1);

   // Reciprocal for the divide by the sample count: floor(2^32 / N).
   localparam int RECIP_SH = 32;
   localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SH) / SAMPLES_PER_FETCH);

   // Q2.30 Taylor coefficients of sin(pi/2 * x), highest order first.
   localparam logic [31:0] SIN_C4 = 32'd172272;
   localparam logic [31:0] SIN_C3 = 32'd5026994;
   localparam logic [31:0] SIN_C2 = 32'd85569305;
   localparam logic [31:0] SIN_C1 = 32'd693598668;
   localparam logic [31:0] SIN_C0 = 32'd1686629713;

   localparam int DIVIDEND_W = 33;
   localparam int DIVISOR_W  = 12;
   localparam int STEP_W     = 24;

   typedef enum logic [2:0] {
      ST_STORED     = 3'd0,
      ST_FIFO_FULL  = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_SAMPLES    = 3'd3,
      ST_EMPTY      = 3'd4,
      ST_NOT_FOUND  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_RESULT,
      S_RECORD,
      S_DIVIDE,
      S_MATH,
      S_PAIR
   } state_type;

   typedef struct packed {
      logic                      kind;
      logic [15:0]               line_id;
      logic [7:0]                line_type;
      logic [FREQ_W-1:0]         frequency;
      logic signed [23:0]        amplitude;
   } req_type;

   typedef struct packed {
      logic [2:0]                status;
      logic [FREQ_W-1:0]         record_frequency;
      logic [MAG_W-1:0]          record_amplitude;
      logic [5:0]                pair_index;
      logic signed [SMP_W-1:0]   sample_even;
      logic signed [SMP_W-1:0]   sample_odd;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic       out_free;
      logic [5:0] scale;
   } eng_ctl_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } eng_out_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

endpackage

// ===== sv/plrf_mul.sv =====
module plrf_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] product
);
   logic [63:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= 64'(mul_a) * 64'(mul_b);
   end

   assign product = product_ff;
endmodule

// ===== sv/plrf_div.sv =====
module plrf_div (
   input  logic                clock,
   input  logic                reset,
   input  plrf_pkg::div_req_type div_req,
   output logic                done,
   output logic [plrf_pkg::STEP_W-1:0] quotient
);
   import plrf_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    shifted;
   logic                  fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_W'(shifted - {1'b0, dsr_ff}) : DIVISOR_W'(shifted);
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[STEP_W-1:0];
endmodule

// ===== sv/plrf_engine.sv =====
module plrf_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  plrf_pkg::req_type     req_data,
   input  plrf_pkg::eng_ctl_type ctl,
   output logic                  eng_ready,
   output plrf_pkg::eng_out_type eng_out
);
   import plrf_pkg::*;
   `include "per_line_record_fifo_sine_synth_core_assert.svh"

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SLOT_W-1:0]  head;
      logic [FILL_W-1:0]  fill;
      logic [ENV_W-1:0]   prev;
      logic [PHASE_W-1:0] phase;
   } ent_type;

   function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] head,
                                                   logic [FILL_W-1:0] fill);
      logic [FILL_W:0] sum;
      sum = (FILL_W + 1)'(head) + (FILL_W + 1)'(fill);
      if (sum >= (FILL_W + 1)'(FIFO_DEPTH)) sum = sum - (FILL_W + 1)'(FIFO_DEPTH);
      return sum[SLOT_W-1:0];
   endfunction

   function automatic logic [REC_AW-1:0] rec_addr(logic [LINE_W-1:0] line,
                                                  logic [SLOT_W-1:0] slot);
      return REC_AW'(REC_AW'(line) * REC_AW'(FIFO_DEPTH) + REC_AW'(slot));
   endfunction

   // Memories: line table and record store.
   ent_type            line_mem [MAX_LINES];
   logic [REC_W-1:0]   rec_mem  [REC_DEPTH];
   ent_type            line_rd_ff;
   logic [REC_W-1:0]   rec_rd_ff;

   logic               line_we;
   logic [LINE_W-1:0]  line_waddr, line_raddr;
   ent_type            line_wdata;
   logic               rec_we;
   logic [REC_AW-1:0]  rec_waddr, rec_raddr;
   logic [REC_W-1:0]   rec_wdata;

   state_type          state_ff, state_in;
   logic [3:0]         st_ff, st_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               kind_ff, kind_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   status_type         res_ff, res_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   ent_type            ent_ff, ent_in;
   logic [ENV_W-1:0]   amp_ff, amp_in;
   logic signed [ENV_W:0] delta_ff, delta_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [PHASE_W-1:0] ph_ff, ph_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SAMP_W-1:0]  j_ff, j_in;
   logic [ENV_W-1:0]   env_ff, env_in;
   logic [16:0]        x_ff, x_in;
   logic [16:0]        x2_ff, x2_in;
   logic [SMP_W-1:0]   even_ff, even_in;
   logic [SMP_W-1:0]   odd_ff, odd_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        product;
   div_req_type        div_req;
   logic               div_done;
   logic [STEP_W-1:0]  div_quo;

   // Combinational helpers.
   logic [23:0]        neg_amp;
   logic [MAG_W-1:0]   in_mag;
   logic [19:0]        q_est;
   logic [NUM_W-1:0]   q_rem;
   logic [16:0]        x_raw;
   logic [31:0]        s_raw;
   logic [17:0]        s_round;
   logic [16:0]        s_clamp;
   logic [35:0]        mag_sum;
   logic [SMP_W-1:0]   smp;
   logic [NUM_W:0]     num_next;
   logic [DIVISOR_W-1:0] divisor;
   logic [SLOT_W-1:0]  head_next;
   logic               sample_last;

   plrf_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   plrf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      freq_in  = freq_ff;
      mag_in   = mag_ff;
      res_in   = res_ff;
      line_in  = line_ff;
      ent_in   = ent_ff;
      amp_in   = amp_ff;
      delta_in = delta_ff;
      num_in   = num_ff;
      ph_in    = ph_ff;
      step_in  = step_ff;
      j_in     = j_ff;
      env_in   = env_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      even_in  = even_ff;
      odd_in   = odd_ff;

      line_we    = 1'b0;
      line_waddr = idx_ff[LINE_W-1:0];
      line_wdata = line_rd_ff;
      line_raddr = idx_ff[LINE_W-1:0];
      rec_we     = 1'b0;
      rec_waddr  = '0;
      rec_wdata  = {freq_ff, mag_ff};
      rec_raddr  = rec_addr(idx_ff[LINE_W-1:0], line_rd_ff.head);

      mul_a = '0;
      mul_b = '0;
      divisor = DIVISOR_W'(ctl.scale * 48);
      div_req.start    = 1'b0;
      div_req.divisor  = divisor;
      div_req.dividend = DIVIDEND_W'({rec_rd_ff[REC_W-1:MAG_W], 8'h00})
                         + DIVIDEND_W'(divisor >> 1);

      eng_out.valid = 1'b0;
      eng_out.data  = '0;
      eng_out.data.last = 1'b1;
      eng_out.data.status = res_ff;

      neg_amp = 24'(~req_data.amplitude + 24'd1);
      if (!req_data.amplitude[23]) in_mag = req_data.amplitude[MAG_W-1:0];
      else if (neg_amp[23])        in_mag = {MAG_W{1'b1}};
      else                         in_mag = neg_amp[MAG_W-1:0];

      q_est   = product[RECIP_SH +: 20];
      q_rem   = NUM_W'(num_ff - NUM_W'(q_est * SAMPLES_PER_FETCH));
      x_raw   = {1'b0, ph_ff[21:6]};
      s_raw   = product[47:16];
      s_round = 18'((33'(s_raw) + 33'd8192) >> 14);
      s_clamp = (s_round > 18'd65536) ? 17'd65536 : s_round[16:0];
      mag_sum = product[35:0] + 36'd32768;
      smp     = ph_ff[23] ? SMP_W'(-{1'b0, mag_sum[34:16]}) : SMP_W'({1'b0, mag_sum[34:16]});
      num_next = (NUM_W + 1)'($signed({1'b0, num_ff})
                 + $signed({{(NUM_W - ENV_W){delta_ff[ENV_W]}}, delta_ff}));
      head_next = (ent_ff.head == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : SLOT_W'(ent_ff.head + 1'b1);
      sample_last = (j_ff == SAMP_W'(SAMPLES_PER_FETCH - 1));

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.kind;
               key_in   = {req_data.line_id, req_data.line_type};
               freq_in  = req_data.frequency;
               mag_in   = in_mag;
               idx_in   = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (idx_ff == count_ff) begin
               if (kind_ff) begin
                  res_in = ST_NOT_FOUND;
               end else if (count_ff >= COUNT_W'(MAX_LINES)) begin
                  res_in = ST_TABLE_FULL;
               end else begin
                  line_we    = 1'b1;
                  line_wdata = '{key: key_ff, head: '0, fill: FILL_W'(1), prev: '0, phase: '0};
                  rec_we     = 1'b1;
                  rec_waddr  = rec_addr(idx_ff[LINE_W-1:0], '0);
                  count_in   = count_ff + 1'b1;
                  res_in     = ST_STORED;
               end
               state_in = S_RESULT;
            end else begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (line_rd_ff.key != key_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SEARCH;
            end else if (!kind_ff) begin
               if (line_rd_ff.fill >= FILL_W'(FIFO_DEPTH)) begin
                  res_in = ST_FIFO_FULL;
               end else begin
                  rec_we     = 1'b1;
                  rec_waddr  = rec_addr(idx_ff[LINE_W-1:0],
                                        slot_add(line_rd_ff.head, line_rd_ff.fill));
                  line_we    = 1'b1;
                  line_wdata.fill = line_rd_ff.fill + 1'b1;
                  res_in     = ST_STORED;
               end
               state_in = S_RESULT;
            end else if (line_rd_ff.fill == '0) begin
               res_in   = ST_EMPTY;
               state_in = S_RESULT;
            end else begin
               ent_in   = line_rd_ff;
               line_in  = idx_ff[LINE_W-1:0];
               state_in = S_RECORD;
            end
         end
         S_RESULT: begin
            if (ctl.out_free) begin
               eng_out.valid = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RECORD: begin
            freq_in = rec_rd_ff[REC_W-1:MAG_W];
            mag_in  = rec_rd_ff[MAG_W-1:0];
            amp_in  = (rec_rd_ff[MAG_W-1:0] > MAG_W'(AMP_CLAMP))
                      ? ENV_W'(AMP_CLAMP) : rec_rd_ff[ENV_W-1:0];
            delta_in = $signed({1'b0, amp_in}) - $signed({1'b0, ent_ff.prev});
            num_in  = NUM_W'(ent_ff.prev * SAMPLES_PER_FETCH + SAMPLES_PER_FETCH / 2);
            ph_in   = ent_ff.phase;
            j_in    = '0;
            div_req.start = 1'b1;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_done) begin
               step_in  = div_quo;
               st_in    = '0;
               state_in = S_MATH;
            end
         end
         S_MATH: begin
            st_in = st_ff + 1'b1;
            case (st_ff)
               4'd0: begin
                  mul_a = 32'(num_ff);
                  mul_b = RECIP;
               end
               4'd1: begin
                  env_in = (q_rem >= NUM_W'(SAMPLES_PER_FETCH))
                           ? ENV_W'(q_est + 1'b1) : ENV_W'(q_est);
                  x_in   = ph_ff[22] ? 17'(17'd65536 - x_raw) : x_raw;
                  mul_a  = 32'(x_in);
                  mul_b  = 32'(x_in);
               end
               4'd2: begin
                  x2_in = product[32:16];
                  mul_a = 32'(product[32:16]);
                  mul_b = SIN_C4;
               end
               4'd3: begin
                  mul_a = 32'(x2_ff);
                  mul_b = SIN_C3 - s_raw;
               end
               4'd4: begin
                  mul_a = 32'(x2_ff);
                  mul_b = SIN_C2 - s_raw;
               end
               4'd5: begin
                  mul_a = 32'(x2_ff);
                  mul_b = SIN_C1 - s_raw;
               end
               4'd6: begin
                  mul_a = 32'(x_ff);
                  mul_b = SIN_C0 - s_raw;
               end
               4'd7: begin
                  mul_a = 32'(env_ff);
                  mul_b = 32'(s_clamp);
               end
               4'd8: begin
                  if (!j_ff[0]) even_in = smp;
                  else          odd_in  = smp;
                  if (j_ff[0] || sample_last) begin
                     if (!j_ff[0]) odd_in = '0;
                     state_in = S_PAIR;
                  end else begin
                     j_in   = j_ff + 1'b1;
                     ph_in  = ph_ff + step_ff;
                     num_in = num_next[NUM_W-1:0];
                     st_in  = '0;
                  end
               end
               default: begin
                  st_in = '0;
               end
            endcase
         end
         S_PAIR: begin
            if (ctl.out_free) begin
               eng_out.valid = 1'b1;
               eng_out.data.status           = ST_SAMPLES;
               eng_out.data.record_frequency = freq_ff;
               eng_out.data.record_amplitude = mag_ff;
               eng_out.data.pair_index       = 6'(j_ff >> 1);
               eng_out.data.sample_even      = even_ff;
               eng_out.data.sample_odd       = odd_ff;
               eng_out.data.last             = sample_last;
               if (sample_last) begin
                  line_we    = 1'b1;
                  line_waddr = line_ff;
                  line_wdata = '{key: ent_ff.key, head: head_next,
                                 fill: ent_ff.fill - 1'b1, prev: amp_ff,
                                 phase: ph_ff + step_ff};
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  ph_in    = ph_ff + step_ff;
                  num_in   = num_next[NUM_W-1:0];
                  st_in    = '0;
                  state_in = S_MATH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      st_ff    <= st_in;
      idx_ff   <= idx_in;
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      freq_ff  <= freq_in;
      mag_ff   <= mag_in;
      res_ff   <= res_in;
      line_ff  <= line_in;
      ent_ff   <= ent_in;
      amp_ff   <= amp_in;
      delta_ff <= delta_in;
      num_ff   <= num_in;
      ph_ff    <= ph_in;
      step_ff  <= step_in;
      j_ff     <= j_in;
      env_ff   <= env_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      even_ff  <= even_in;
      odd_ff   <= odd_in;
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_waddr] <= line_wdata;
      end
      line_rd_ff <= line_mem[line_raddr];
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_rd_ff <= rec_mem[rec_raddr];
   end

   assign eng_ready = (state_ff == S_IDLE);

   `PLRF_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= COUNT_W'(MAX_LINES), "line count overflow")
   `PLRF_ASSERT_IMPL(a_fill_bound, line_we, line_wdata.fill <= FILL_W'(FIFO_DEPTH), "fill overflow")
   `PLRF_ASSERT_IMPL(a_emit_free, eng_out.valid, ctl.out_free, "result emitted into a busy slot")
   `PLRF_ASSERT_NEXT(a_accept_search, state_ff == S_IDLE && req_valid, state_ff == S_SEARCH,
                     "accepted word did not start a search")
endmodule

// ===== sv/per_line_record_fifo_sine_synth_core.sv =====
// Channel   Direction  Handshake          Word
// req       in         req_valid/stall    plrf_pkg::req_type (store or fetch)
// rsp       out        rsp_valid/stall    plrf_pkg::rsp_type (status or sample pair)
// csr       in         csr_valid/ready    display_scale, 6 bits
//
// One word is worked at a time. The line search reads the line table entry by entry,
// comparing each key in turn. A store then gives its result. A fetch adds a record
// read, the 33-step serial phase step divide, and a serial sine evaluation per sample
// on the shared multiplier, plus a hand-out step for each pair of samples.
// Reset is synchronous and clears the line count, so no memory clearing pass is needed.
// A stalled result holds the engine only when the output register is full.
module per_line_record_fifo_sine_synth_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plrf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [5:0]        csr_data
);
   import plrf_pkg::*;

   // The scale register accepts only values one to fifty; any other write is dropped.
   logic [5:0]  scale_ff;
   // The output register decouples the engine from a stalled consumer.
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic        eng_ready;
   eng_ctl_type ctl;
   eng_out_type eng_out;

   assign csr_ready    = 1'b1;
   assign ctl.out_free = !rsp_valid_ff || !rsp_stall;
   assign ctl.scale    = scale_ff;
   assign req_stall    = !eng_ready;

   plrf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .ctl       (ctl),
      .eng_ready (eng_ready),
      .eng_out   (eng_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 6'd1;
      end else if (csr_valid && (csr_data inside {[6'd1:6'd50]})) begin
         scale_ff <= csr_data;
      end
   end

   // A new word from the engine always finds the slot free, so it may simply overwrite.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_out.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (eng_out.valid) begin
         rsp_data_ff <= eng_out.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== bench/tb_per_line_record_fifo_sine_synth_core.sv =====
`timescale 1ns / 100ps

module tb_per_line_record_fifo_sine_synth_core;
   import plrf_pkg::*;

   // Codes of the kind field of a request word.
   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [5:0] csr_data = 6'd0;

   per_line_record_fifo_sine_synth_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // The clock runs at a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Words waiting to be offered, and the result words that the line model predicts.
   req_type pending_words[$];
   rsp_type expected_rsp[$];
   int      error_count = 0;
   int      checked_count = 0;
   bit      quiet = 1'b0;

   // Shadow copy of the block's state, kept in step with accepted words.
   logic [5:0]  scale_model = 6'd1;
   logic [23:0] key_model[MAX_LINES];
   int          lines_used = 0;
   int          fill_model[MAX_LINES];
   longint unsigned prev_amp_model[MAX_LINES];
   logic [23:0] phase_model[MAX_LINES];
   logic [23:0] freq_model[MAX_LINES][FIFO_DEPTH];
   logic [22:0] mag_model[MAX_LINES][FIFO_DEPTH];

   // Keys of the sixteen lines that the table ends up holding.
   logic [23:0] line_keys[MAX_LINES];

   // Quarter-wave sine in Q.16 from a Q0.16 argument, by the Horner polynomial.
   function automatic longint unsigned quarter_sine(longint unsigned x);
      longint unsigned x2, t, s;
      x2 = (x * x) >> 16;
      t = 64'd5026994 - ((x2 * 64'd172272) >> 16);
      t = 64'd85569305 - ((x2 * t) >> 16);
      t = 64'd693598668 - ((x2 * t) >> 16);
      t = 64'd1686629713 - ((x2 * t) >> 16);
      s = (x * t) >> 16;
      s = (s + 64'd8192) >> 14;
      return (s > 64'd65536) ? 64'd65536 : s;
   endfunction

   function automatic logic [SMP_W-1:0] sine_sample(logic [23:0] ph, longint unsigned env);
      longint unsigned x, mag;
      x = 64'(ph[21:6]);
      if (ph[22]) x = 64'd65536 - x;
      mag = (env * quarter_sine(x) + 64'd32768) >> 16;
      if (ph[23]) mag = -mag;
      return mag[SMP_W-1:0];
   endfunction

   function automatic rsp_type status_word(status_type st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   // Updates the line model with one accepted word and queues the results it causes.
   task automatic predict_line_word(req_type w);
      logic [23:0] key, raw;
      logic [24:0] mag;
      int li, n, k, h, j;
      longint unsigned amp, prev, step, d, env;
      logic [SMP_W-1:0] s[2];
      rsp_type r;
      key = {w.line_id, w.line_type};
      li = -1;
      for (int i = 0; i < lines_used; i++)
         if (key_model[i] == key && li < 0) li = i;
      if (w.kind == KIND_STORE) begin
         if (li < 0 && lines_used >= MAX_LINES) begin
            expected_rsp.push_back(status_word(ST_TABLE_FULL));
            return;
         end
         if (li < 0) begin
            li = lines_used;
            key_model[li] = key;
            fill_model[li] = 0;
            prev_amp_model[li] = 0;
            phase_model[li] = '0;
            lines_used++;
         end
         n = fill_model[li];
         if (n >= FIFO_DEPTH) begin
            expected_rsp.push_back(status_word(ST_FIFO_FULL));
            return;
         end
         raw = w.amplitude;
         mag = raw[23] ? (25'h1000000 - raw) : {1'b0, raw};
         if (mag > 25'h7FFFFF) mag = 25'h7FFFFF;
         freq_model[li][n] = w.frequency;
         mag_model[li][n] = mag[22:0];
         fill_model[li] = n + 1;
         expected_rsp.push_back(status_word(ST_STORED));
         return;
      end
      if (li < 0) begin
         expected_rsp.push_back(status_word(ST_NOT_FOUND));
         return;
      end
      if (fill_model[li] == 0) begin
         expected_rsp.push_back(status_word(ST_EMPTY));
         return;
      end
      amp = (mag_model[li][0] > 23'(AMP_CLAMP)) ? 64'(AMP_CLAMP) : 64'(mag_model[li][0]);
      prev = prev_amp_model[li];
      d = 64'(48 * scale_model);
      step = ((longint'(freq_model[li][0]) << 8) + d / 2) / d;
      for (k = 0; k < SAMPLES_PER_FETCH / 2; k++) begin
         for (h = 0; h < 2; h++) begin
            j = 2 * k + h;
            env = (prev * (SAMPLES_PER_FETCH - j) + amp * j + SAMPLES_PER_FETCH / 2)
                  / SAMPLES_PER_FETCH;
            s[h] = sine_sample(24'(phase_model[li] + j * step), env);
         end
         r = '0;
         r.status = ST_SAMPLES;
         r.record_frequency = freq_model[li][0];
         r.record_amplitude = mag_model[li][0];
         r.pair_index = 6'(k);
         r.sample_even = s[0];
         r.sample_odd = s[1];
         r.last = (k == SAMPLES_PER_FETCH / 2 - 1);
         expected_rsp.push_back(r);
      end
      prev_amp_model[li] = amp;
      phase_model[li] = 24'(phase_model[li] + SAMPLES_PER_FETCH * step);
      for (int i = 0; i + 1 < fill_model[li]; i++) begin
         freq_model[li][i] = freq_model[li][i + 1];
         mag_model[li][i] = mag_model[li][i + 1];
      end
      fill_model[li]--;
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch at result %0d: %s got %h expected %h", checked_count, field,
               got, want);
      error_count++;
   endtask

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The driver offers pending words one at a time and predicts each one as it
   // is accepted. A stalled word stays on the bus unchanged.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_line_word(req_data);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The monitor checks each accepted result word against the oldest prediction.
   // Once, early in the run, it holds the result channel off for a long stretch
   // so that the block backs up and stalls its input while the driver keeps offering.
   int  stall_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected word, status", 32'(rsp_data.status), 32'd0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.record_frequency !== want.record_frequency)
                  report_mismatch("record_frequency", 32'(rsp_data.record_frequency),
                                  32'(want.record_frequency));
               if (rsp_data.record_amplitude !== want.record_amplitude)
                  report_mismatch("record_amplitude", 32'(rsp_data.record_amplitude),
                                  32'(want.record_amplitude));
               if (rsp_data.pair_index !== want.pair_index)
                  report_mismatch("pair_index", 32'(rsp_data.pair_index),
                                  32'(want.pair_index));
               if (rsp_data.sample_even !== want.sample_even)
                  report_mismatch("sample_even", 32'(unsigned'(rsp_data.sample_even)),
                                  32'(unsigned'(want.sample_even)));
               if (rsp_data.sample_odd !== want.sample_odd)
                  report_mismatch("sample_odd", 32'(unsigned'(rsp_data.sample_odd)),
                                  32'(unsigned'(want.sample_odd)));
               if (rsp_data.last !== want.last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
            end
            checked_count++;
         end
         if (!hold_done && checked_count >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 4000;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_gap <= pick_gap();
         end
      end
   end

   function automatic req_type make_word(logic kind, logic [23:0] key, logic [23:0] freq,
                                         logic [23:0] amp);
      req_type w;
      w.kind = kind;
      w.line_id = key[23:8];
      w.line_type = key[7:0];
      w.frequency = freq;
      w.amplitude = amp;
      return w;
   endfunction

   // A random word: mostly one of the known lines, sometimes a stray key that
   // meets a full table or an unknown line.
   function automatic req_type random_word();
      logic [23:0] key, freq;
      int r;
      key = line_keys[$urandom_range(0, MAX_LINES - 1)];
      if ($urandom_range(0, 99) < 8) key = 24'($urandom);
      r = $urandom_range(0, 99);
      freq = (r < 5) ? 24'hFFFFFF : (r < 10) ? 24'h0 : (r < 60) ? 24'($urandom) :
             24'($urandom_range(0, 24'h3FFFFF));
      return make_word(($urandom_range(0, 99) < 40) ? KIND_FETCH : KIND_STORE, key,
                       freq, 24'($urandom));
   endfunction

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Writes display_scale; values outside 1..50 must leave the register alone.
   task automatic write_scale(logic [5:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (value >= 1 && value <= 50) scale_model = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [5:0] scales[8];
      scales = '{6'd1, 6'd0, 6'd50, 6'd63, 6'd7, 6'd51, 6'd1, 6'd23};
      line_keys[0] = 24'h000000;
      line_keys[1] = 24'hFFFFFF;
      for (int i = 2; i < MAX_LINES; i++) line_keys[i] = {8'(i), 16'($urandom)};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words: unknown line, empty line, extreme fields, a full FIFO
      // and, last, a full table.
      write_scale(6'd50);
      pending_words.push_back(make_word(KIND_FETCH, line_keys[0], '0, '0));
      pending_words.push_back(make_word(KIND_STORE, line_keys[0], 24'hFFFFFF, 24'h800000));
      pending_words.push_back(make_word(KIND_FETCH, line_keys[0], '0, '0));
      pending_words.push_back(make_word(KIND_FETCH, line_keys[0], '0, '0));
      pending_words.push_back(make_word(KIND_STORE, line_keys[1], 24'h000000, 24'h7FFFFF));
      pending_words.push_back(make_word(KIND_STORE, line_keys[1], 24'h123456, 24'h000000));
      pending_words.push_back(make_word(KIND_FETCH, line_keys[1], '0, '0));
      for (int i = 0; i < FIFO_DEPTH + 1; i++)
         pending_words.push_back(make_word(KIND_STORE, line_keys[2], 24'($urandom),
                                           24'($urandom)));
      for (int i = 3; i < MAX_LINES; i++)
         pending_words.push_back(make_word(KIND_STORE, line_keys[i], 24'($urandom),
                                           24'($urandom_range(0, 24'h0FFFFF))));
      pending_words.push_back(make_word(KIND_STORE, 24'h5A5A5A, 24'h1, 24'h1));
      wait_idle();

      // Random phases, each under its own scale write; the last phase has no idling.
      foreach (scales[p]) begin
         write_scale(scales[p]);
         quiet = (p == 7);
         for (int i = 0; i < 60; i++) pending_words.push_back(random_word());
         wait_idle();
      end

      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/plrf_pkg.sv
sv/plrf_mul.sv
sv/plrf_div.sv
sv/plrf_engine.sv
sv/per_line_record_fifo_sine_synth_core.sv
bench/tb_per_line_record_fifo_sine_synth_core.sv
